[rtl/core/thread_table_round_robin_top_defines.svh]
// Assertion macros for the thread table round-robin scheduler.
`ifndef THREAD_TABLE_ROUND_ROBIN_TOP_DEFINES_SVH
`define THREAD_TABLE_ROUND_ROBIN_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked outside reset only.
`define TTRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TTRR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTRR_ASSERT(label, prop, msg)
`define TTRR_ASSERT_RST(label, prop, msg)
`endif
`endif

[rtl/core/ttrr_pkg.sv]
// Types, codes and constants shared by the thread table scheduler files.
package ttrr_pkg;

  localparam int ENTRIES   = 8;
  localparam int IW        = $clog2(ENTRIES);
  localparam int WORD_W    = 16;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int ERR_W     = 2;
  localparam int IDX_OUT_W = 3;

  typedef logic [IW-1:0] idx_t;

  localparam idx_t LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [WORD_W-1:0] START_SP = 16'h0100;

  // operation codes
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_YIELD   = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPOSE = 2'd2;

  // thread status codes
  localparam logic [ST_W-1:0] ST_NEW     = 2'd0;
  localparam logic [ST_W-1:0] ST_BLOCKED = 2'd1;
  localparam logic [ST_W-1:0] ST_RUNNING = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_FREE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_THREAD = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] code_segment;
    logic [WORD_W-1:0] code_offset;
    logic [WORD_W-1:0] saved_stack_segment;
    logic [WORD_W-1:0] saved_stack_pointer;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic [ST_W-1:0]      entry_status;
    logic [WORD_W-1:0]    run_segment;
    logic [WORD_W-1:0]    run_offset;
    logic [WORD_W-1:0]    run_stack_segment;
    logic [WORD_W-1:0]    run_stack_pointer;
    logic                 switch_now;
    logic                 to_kernel;
    logic [ERR_W-1:0]     error;
  } out_item_t;

  // one word of the link memory
  typedef struct packed {
    logic [ST_W-1:0] status;
    idx_t            prev;
    idx_t            next;
  } link_t;

  // one word of the context memory
  typedef struct packed {
    logic [WORD_W-1:0] seg;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] ss;
    logic [WORD_W-1:0] sp;
  } ctx_t;

  localparam int LINK_W = $bits(link_t);
  localparam int CTX_W  = $bits(ctx_t);

  // bit write masks into a link word
  localparam link_t LM_NEXT   = '{status: 2'b00, prev: '0, next: '1};
  localparam link_t LM_PREV   = '{status: 2'b00, prev: '1, next: '0};
  localparam link_t LM_LINKS  = '{status: 2'b00, prev: '1, next: '1};
  localparam link_t LM_STATUS = '{status: 2'b11, prev: '0, next: '0};
  localparam link_t LM_ALL    = '{status: 2'b11, prev: '1, next: '1};

endpackage

[rtl/core/ttrr_in_if.sv]
// Valid/ready channel carrying one scheduler request.
interface ttrr_in_if import ttrr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ttrr_out_if.sv]
// Valid/ready channel carrying one scheduler result.
interface ttrr_out_if import ttrr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ttrr_ram.sv]
// Generic simple dual-port RAM: bit-masked write, registered read (old data on collision).
module ttrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [WIDTH-1:0]         wmask,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/thread_table_round_robin_top.sv]
// Top level of the round-robin thread table scheduler with free ring.
//
//  channel  | dir | transfer when          | carries
//  ---------+-----+------------------------+------------------------------------
//  in_ch    | in  | in_ch.valid & ready    | operation, code/stack context
//  out_ch   | out | out_ch.valid & ready   | entry, status, context, flags, error
//
// Requests: one at a time. From the input transfer to the result reaching the
// output register, errors and unused codes go from decode to output; yield runs
// S_RUN and S_CTX, after S_Y_NXT when saving the current thread; create and dispose
// run the unlink and relink states, and a switching dispose then S_RUN and S_CTX.
// Each ring unlink and relink touches one link word per cycle (single write port).
// Reset: synchronous, then a clearing pass over every entry builds the free ring
// in the link memory; no request is taken until it ends.
// Stalls: a result waits in the output register while the next request is taken
// and worked on; that one waits for the register before it is loaded.
`include "thread_table_round_robin_top_defines.svh"

module thread_table_round_robin_top import ttrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ttrr_in_if.sink     in_ch,
  ttrr_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_INIT,    // clearing pass over the link memory
    S_IDLE,    // waiting for a request
    S_DISP,    // decode, check, issue first reads and writes
    S_MV_UNA,  // unlink: fix next of predecessor, read destination head
    S_MV_UNB,  // unlink: fix prev of successor
    S_MV_LKE,  // relink: write the moving entry
    S_MV_LKH,  // relink: fix next of destination head
    S_MV_LKN,  // relink: fix prev of old head successor, update heads
    S_Y_NXT,   // yield: pick up successor of current entry
    S_RUN,     // mark target running, read its context
    S_CTX,     // build result from restored context
    S_OUT      // hand result to output register
  } state_t;

  state_t    state_r, state_nxt;
  in_item_t  in_r, in_nxt;
  idx_t      e_r, e_nxt;        // entry being moved between rings
  idx_t      t_r, t_nxt;        // entry about to run
  idx_t      nu_r, nu_nxt;      // successor of moving entry
  idx_t      pu_r, pu_nxt;      // predecessor of moving entry
  idx_t      nh_r, nh_nxt;      // successor of destination head
  logic      to_ready_r, to_ready_nxt;
  idx_t      free_head_r, free_head_nxt;
  logic      free_valid_r, free_valid_nxt;
  idx_t      ready_head_r, ready_head_nxt;
  logic      ready_valid_r, ready_valid_nxt;
  idx_t      cur_r, cur_nxt;
  logic      cur_valid_r, cur_valid_nxt;
  idx_t      init_cnt_r, init_cnt_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // link memory ports
  logic  lw_en;
  idx_t  lw_addr, lr_addr;
  link_t lw_data, lw_mask, lr_data;
  // context memory ports
  logic  cw_en;
  idx_t  cw_addr, cr_addr;
  ctx_t  cw_data, cr_data;

  idx_t  dst_head;
  logic  dst_valid;
  logic  src_empty;

  // destination ring of a move: ready ring for create, free ring for dispose
  assign dst_head  = to_ready_r ? ready_head_r  : free_head_r;
  assign dst_valid = to_ready_r ? ready_valid_r : free_valid_r;
  // source ring empties when the moving entry linked to itself
  assign src_empty = (nu_r == e_r);

  ttrr_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .wmask (lw_mask),
    .raddr (lr_addr),
    .rdata (lr_data)
  );

  ttrr_ram #(.WIDTH(CTX_W), .DEPTH(ENTRIES)) u_ctx_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .wmask ({CTX_W{1'b1}}),
    .raddr (cr_addr),
    .rdata (cr_data)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    state_nxt       = state_r;
    in_nxt          = in_r;
    e_nxt           = e_r;
    t_nxt           = t_r;
    nu_nxt          = nu_r;
    pu_nxt          = pu_r;
    nh_nxt          = nh_r;
    to_ready_nxt    = to_ready_r;
    free_head_nxt   = free_head_r;
    free_valid_nxt  = free_valid_r;
    ready_head_nxt  = ready_head_r;
    ready_valid_nxt = ready_valid_r;
    cur_nxt         = cur_r;
    cur_valid_nxt   = cur_valid_r;
    init_cnt_nxt    = init_cnt_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;

    lw_en   = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    lw_mask = '0;
    lr_addr = '0;
    cw_en   = 1'b0;
    cw_addr = '0;
    cw_data = '0;
    cr_addr = '0;

    // output register drains on its own transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        // entry i: next i+1, prev i-1, both wrapping; status new
        lw_en          = 1'b1;
        lw_addr        = init_cnt_r;
        lw_mask        = LM_ALL;
        lw_data.status = ST_NEW;
        lw_data.next   = (init_cnt_r == LAST_IDX) ? '0 : init_cnt_r + idx_t'(1);
        lw_data.prev   = (init_cnt_r == '0) ? LAST_IDX : init_cnt_r - idx_t'(1);
        init_cnt_nxt   = init_cnt_r + idx_t'(1);
        if (init_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          in_nxt    = in_ch.data;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_nxt = '0;
        unique case (in_r.operation)
          OP_CREATE: begin
            if (!free_valid_r) begin
              res_nxt.error = ERR_NO_FREE;
              state_nxt     = S_OUT;
            end else begin
              e_nxt        = free_head_r;
              lr_addr      = free_head_r;
              cw_en        = 1'b1;
              cw_addr      = free_head_r;
              cw_data      = '{seg: in_r.code_segment, off: in_r.code_offset,
                               ss: in_r.code_segment, sp: START_SP};
              to_ready_nxt = 1'b1;
              state_nxt    = S_MV_UNA;
            end
          end
          OP_YIELD: begin
            if (cur_valid_r) begin
              // save outgoing context, mark blocked, fetch its successor
              cw_en          = 1'b1;
              cw_addr        = cur_r;
              cw_data        = '{seg: in_r.code_segment, off: in_r.code_offset,
                                 ss: in_r.saved_stack_segment,
                                 sp: in_r.saved_stack_pointer};
              lw_en          = 1'b1;
              lw_addr        = cur_r;
              lw_data.status = ST_BLOCKED;
              lw_mask        = LM_STATUS;
              lr_addr        = cur_r;
              state_nxt      = S_Y_NXT;
            end else if (ready_valid_r) begin
              t_nxt     = ready_head_r;
              state_nxt = S_RUN;
            end else begin
              res_nxt.error = ERR_NO_THREAD;
              state_nxt     = S_OUT;
            end
          end
          OP_DISPOSE: begin
            if (!cur_valid_r) begin
              res_nxt.error = ERR_NO_THREAD;
              state_nxt     = S_OUT;
            end else begin
              e_nxt        = cur_r;
              lr_addr      = cur_r;
              to_ready_nxt = 1'b0;
              state_nxt    = S_MV_UNA;
            end
          end
          default: begin
            // unused code: all-zero result, no state change
            state_nxt = S_OUT;
          end
        endcase
      end

      S_MV_UNA: begin
        nu_nxt = lr_data.next;
        pu_nxt = lr_data.prev;
        if (lr_data.next != e_r) begin
          lw_en        = 1'b1;
          lw_addr      = lr_data.prev;
          lw_data.next = lr_data.next;
          lw_mask      = LM_NEXT;
        end
        // rings are disjoint, so this read never meets the write above
        lr_addr   = dst_head;
        state_nxt = S_MV_UNB;
      end

      S_MV_UNB: begin
        nh_nxt = lr_data.next;
        if (!src_empty) begin
          lw_en        = 1'b1;
          lw_addr      = nu_r;
          lw_data.prev = pu_r;
          lw_mask      = LM_PREV;
        end
        state_nxt = S_MV_LKE;
      end

      S_MV_LKE: begin
        lw_en          = 1'b1;
        lw_addr        = e_r;
        lw_data.status = ST_NEW;
        lw_data.prev   = dst_valid ? dst_head : e_r;
        lw_data.next   = dst_valid ? nh_r : e_r;
        // a disposed entry keeps its status
        lw_mask        = to_ready_r ? LM_ALL : LM_LINKS;
        state_nxt      = S_MV_LKH;
      end

      S_MV_LKH: begin
        if (dst_valid) begin
          lw_en        = 1'b1;
          lw_addr      = dst_head;
          lw_data.next = e_r;
          lw_mask      = LM_NEXT;
        end
        state_nxt = S_MV_LKN;
      end

      S_MV_LKN: begin
        // when the head linked to itself this lands on the head's prev
        if (dst_valid) begin
          lw_en        = 1'b1;
          lw_addr      = nh_r;
          lw_data.prev = e_r;
          lw_mask      = LM_PREV;
        end
        if (to_ready_r) begin
          free_valid_nxt            = !src_empty;
          free_head_nxt             = src_empty ? '0 : nu_r;
          ready_head_nxt            = e_r;
          ready_valid_nxt           = 1'b1;
          res_nxt.entry_index       = IDX_OUT_W'(e_r);
          res_nxt.entry_status      = ST_NEW;
          res_nxt.run_segment       = in_r.code_segment;
          res_nxt.run_offset        = in_r.code_offset;
          res_nxt.run_stack_segment = in_r.code_segment;
          res_nxt.run_stack_pointer = START_SP;
          state_nxt                 = S_OUT;
        end else begin
          ready_valid_nxt = !src_empty;
          ready_head_nxt  = src_empty ? '0 : nu_r;
          free_head_nxt   = e_r;
          free_valid_nxt  = 1'b1;
          if (src_empty) begin
            cur_valid_nxt     = 1'b0;
            cur_nxt           = '0;
            res_nxt.to_kernel = 1'b1;
            state_nxt         = S_OUT;
          end else begin
            t_nxt              = nu_r;
            res_nxt.switch_now = 1'b1;
            state_nxt          = S_RUN;
          end
        end
      end

      S_Y_NXT: begin
        t_nxt     = lr_data.next;
        state_nxt = S_RUN;
      end

      S_RUN: begin
        lw_en          = 1'b1;
        lw_addr        = t_r;
        lw_data.status = ST_RUNNING;
        lw_mask        = LM_STATUS;
        cr_addr        = t_r;
        cur_nxt        = t_r;
        cur_valid_nxt  = 1'b1;
        state_nxt      = S_CTX;
      end

      S_CTX: begin
        res_nxt.entry_index       = IDX_OUT_W'(t_r);
        res_nxt.entry_status      = ST_RUNNING;
        res_nxt.run_segment       = cr_data.seg;
        res_nxt.run_offset        = cr_data.off;
        res_nxt.run_stack_segment = cr_data.ss;
        res_nxt.run_stack_pointer = cr_data.sp;
        state_nxt                 = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload, no reset
    in_r       <= in_nxt;
    e_r        <= e_nxt;
    t_r        <= t_nxt;
    nu_r       <= nu_nxt;
    pu_r       <= pu_nxt;
    nh_r       <= nh_nxt;
    to_ready_r <= to_ready_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    if (!rst_n) begin
      state_r       <= S_INIT;
      init_cnt_r    <= '0;
      free_head_r   <= '0;
      free_valid_r  <= 1'b1;
      ready_head_r  <= '0;
      ready_valid_r <= 1'b0;
      cur_r         <= '0;
      cur_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      init_cnt_r    <= init_cnt_nxt;
      free_head_r   <= free_head_nxt;
      free_valid_r  <= free_valid_nxt;
      ready_head_r  <= ready_head_nxt;
      ready_valid_r <= ready_valid_nxt;
      cur_r         <= cur_nxt;
      cur_valid_r   <= cur_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // every entry sits on one ring: an empty free ring means a full ready ring
  `TTRR_ASSERT(a_rings_cover, !free_valid_r |-> ready_valid_r, "free and ready rings both empty")
  // a current thread always sits on the ready ring
  `TTRR_ASSERT(a_cur_on_ready, cur_valid_r |-> ready_valid_r, "current thread with empty ready ring")
  `TTRR_ASSERT(a_flags_excl, out_ch.valid |-> !(out_ch.data.switch_now && out_ch.data.to_kernel), "switch and kernel return together")
  `TTRR_ASSERT(a_accept_disp, (in_ch.valid && in_ch.ready) |=> (state_r == S_DISP), "request taken but not decoded")
  `TTRR_ASSERT_RST(a_reset_init, !rst_n |=> (state_r == S_INIT), "reset did not start clearing pass")

endmodule
